// File: rtl/zpa_pkg.sv
// Shared types and constants for the zone page allocator.
// Used by zpa_ctrl and zone_page_allocator; depends on nothing.
package zpa_pkg;

   // Default sizes of the allocator.
   localparam int PHYS_PAGES_DEF       = 128;
   localparam int SMALL_ZONE_PAGES_DEF = 256;
   localparam int LARGE_ZONE_PAGES_DEF = 1024;
   localparam int NUM_ZONES_DEF        = 6;

   // The one zone that gets the large page limit.
   localparam logic [2:0] LARGE_ZONE_ID = 3'd4;

   // Words are rounded up to pages of 1024 words.
   localparam int         PAGE_SHIFT = 10;
   localparam logic [22:0] WORD_ROUND = 23'd1023;
   localparam int         NEED_W     = 23 - PAGE_SHIFT;

   localparam logic MODE_RESIZE    = 1'b0;
   localparam logic MODE_TRANSLATE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [2:0]  zone;
      logic [21:0] size_words;
      logic [9:0]  virtual_page;
   } request_type;

   typedef struct packed {
      logic        ok;
      logic [10:0] page_count;
      logic [7:0]  free_pages;
      logic [6:0]  physical_page;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RECOUNT,
      ST_EVAL,
      ST_GROW,
      ST_SHR_RD,
      ST_SHR_WR,
      ST_XLAT,
      ST_DONE
   } state_type;

endpackage

// File: rtl/zpa_map_ram.sv
// Zone map memory: one physical page index per zone virtual page.
// Synchronous write, registered read. No dependencies.
module zpa_map_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 7,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// File: rtl/zpa_ctrl.sv
// Sequencer of the zone page allocator: page ownership memory, zone page
// counts, free count and the walk over the zone map memory.
// Depends on zpa_pkg; drives the port of zpa_map_ram.
module zpa_ctrl
   import zpa_pkg::*;
#(
   parameter int PHYS_PAGES       = PHYS_PAGES_DEF,
   parameter int SMALL_ZONE_PAGES = SMALL_ZONE_PAGES_DEF,
   parameter int LARGE_ZONE_PAGES = LARGE_ZONE_PAGES_DEF,
   parameter int NUM_ZONES        = NUM_ZONES_DEF,
   localparam int MAP_ROW = (SMALL_ZONE_PAGES > LARGE_ZONE_PAGES) ?
                            SMALL_ZONE_PAGES : LARGE_ZONE_PAGES,
   localparam int ADDR_W  = $clog2(NUM_ZONES * MAP_ROW),
   localparam int PAGE_W  = $clog2(PHYS_PAGES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   input  logic              req_accept,
   input  request_type       req,
   output logic              req_ready,
   input  logic              slot_free,
   output logic              res_valid,
   output result_type        res,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [PAGE_W-1:0] mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [PAGE_W-1:0] mem_rdata
);

   localparam int CNT_W  = $clog2(MAP_ROW + 1);
   localparam int FREE_W = $clog2(PHYS_PAGES + 1);
   localparam int ZIDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

   state_type         state_ff, state_in;
   request_type       req_ff, req_in;
   result_type        res_ff, res_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [FREE_W-1:0] scan_ff, scan_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [FREE_W-1:0] held_ff, held_in;
   logic              chk_ff, chk_in;
   logic [CNT_W-1:0]  counts_ff [NUM_ZONES];
   logic [CNT_W-1:0]  counts_in [NUM_ZONES];

   // One ownership bit per physical page.
   logic              used_mem [PHYS_PAGES];
   logic              used_we;
   logic [PAGE_W-1:0] used_waddr;
   logic              used_wdata;
   logic              used_re;
   logic [PAGE_W-1:0] used_raddr;
   logic              used_rdata;

   logic              zone_ok;
   logic [ZIDX_W-1:0] zidx;
   logic [CNT_W-1:0]  zone_cur;
   logic [NEED_W-1:0] need_raw;
   logic              need_fits;
   logic [PAGE_W-1:0] sidx;
   logic [PAGE_W-1:0] prev_page;
   logic [FREE_W-1:0] held_new;

   function automatic logic [ADDR_W-1:0] map_addr(input logic [ZIDX_W-1:0] z,
                                                  input logic [CNT_W-1:0] c);
      return ADDR_W'(int'(z) * MAP_ROW + int'(c));
   endfunction

   assign zone_ok  = ({1'b0, req_ff.zone} < 4'(NUM_ZONES));
   assign zidx     = req_ff.zone[ZIDX_W-1:0];
   assign zone_cur = counts_ff[zidx];
   assign need_raw = NEED_W'(({1'b0, req_ff.size_words} + WORD_ROUND) >> PAGE_SHIFT);
   assign need_fits = ((req_ff.zone == LARGE_ZONE_ID) ? (int'(need_raw) <= LARGE_ZONE_PAGES)
                                                      : (int'(need_raw) <= SMALL_ZONE_PAGES))
                      && (int'(need_raw) <= MAP_ROW);
   assign sidx      = scan_ff[PAGE_W-1:0];
   assign prev_page = PAGE_W'(scan_ff - 1'b1);
   assign held_new  = (int'(csr_wdata) > PHYS_PAGES) ? FREE_W'(PHYS_PAGES)
                                                     : FREE_W'(csr_wdata);

   assign req_ready = (state_ff == ST_IDLE) && !csr_we;

   always_comb begin
      res = res_ff;
      res.free_pages = 8'(free_ff);
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      res_in     = res_ff;
      cur_in     = cur_ff;
      need_in    = need_ff;
      scan_in    = scan_ff;
      free_in    = free_ff;
      held_in    = held_ff;
      chk_in     = 1'b0;
      counts_in  = counts_ff;
      used_we    = 1'b0;
      used_waddr = sidx;
      used_wdata = 1'b0;
      used_re    = 1'b0;
      used_raddr = sidx;
      mem_we     = 1'b0;
      mem_waddr  = map_addr(zidx, cur_ff);
      mem_wdata  = prev_page;
      mem_re     = 1'b0;
      mem_raddr  = map_addr(zidx, cur_ff - 1'b1);
      res_valid  = 1'b0;
      if (csr_we && (state_ff != ST_CLEAR)) begin
         // A new reserve restarts the free page recount unless the clearing pass runs.
         held_in  = held_new;
         scan_in  = held_new;
         free_in  = '0;
         state_in = ST_RECOUNT;
      end else begin
         if (csr_we) begin
            // A reserve written during the clearing pass is applied when it ends.
            held_in = held_new;
            free_in = '0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (int'(scan_ff) < PHYS_PAGES) begin
                  used_we = 1'b1;
                  scan_in = scan_ff + 1'b1;
               end else begin
                  free_in  = FREE_W'(PHYS_PAGES) - held_in;
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  req_in   = req;
                  state_in = ST_EVAL;
               end
            end
            ST_RECOUNT: begin
               // Each ownership bit is read from the registered memory and counted in the next cycle.
               if (chk_ff && !used_rdata) begin
                  free_in = free_ff + 1'b1;
               end
               if (int'(scan_ff) < PHYS_PAGES) begin
                  used_re = 1'b1;
                  scan_in = scan_ff + 1'b1;
                  chk_in  = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_EVAL: begin
               res_in.ok            = 1'b0;
               res_in.page_count    = '0;
               res_in.physical_page = '0;
               state_in             = ST_DONE;
               if (zone_ok) begin
                  res_in.page_count = 11'(zone_cur);
                  cur_in            = zone_cur;
                  if (req_ff.mode == MODE_TRANSLATE) begin
                     if ((int'(req_ff.virtual_page) < int'(zone_cur)) &&
                         (int'(req_ff.virtual_page) < MAP_ROW)) begin
                        mem_re    = 1'b1;
                        mem_raddr = map_addr(zidx, CNT_W'(req_ff.virtual_page));
                        state_in  = ST_XLAT;
                     end
                  end else if (need_fits) begin
                     need_in = CNT_W'(need_raw);
                     if (int'(need_raw) > int'(zone_cur)) begin
                        if (int'(need_raw) - int'(zone_cur) <= int'(free_ff)) begin
                           scan_in  = held_ff;
                           state_in = ST_GROW;
                        end
                     end else if (int'(need_raw) == int'(zone_cur)) begin
                        res_in.ok = 1'b1;
                     end else begin
                        state_in = ST_SHR_RD;
                     end
                  end
               end
            end
            ST_GROW: begin
               // Lowest free pages above the reserve are claimed as the scan passes; the
               // ownership bit of the page before the scan pointer arrives now.
               if (chk_ff && !used_rdata && (cur_ff < need_ff)) begin
                  used_we    = 1'b1;
                  used_waddr = prev_page;
                  used_wdata = 1'b1;
                  mem_we     = 1'b1;
                  cur_in     = cur_ff + 1'b1;
                  free_in    = free_ff - 1'b1;
               end
               if ((int'(scan_ff) < PHYS_PAGES) && (cur_in < need_ff)) begin
                  used_re = 1'b1;
                  scan_in = scan_ff + 1'b1;
                  chk_in  = 1'b1;
               end else begin
                  counts_in[zidx]   = cur_in;
                  res_in.ok         = (cur_in == need_ff);
                  res_in.page_count = 11'(cur_in);
                  state_in          = ST_DONE;
               end
            end
            ST_SHR_RD: begin
               if (cur_ff > need_ff) begin
                  mem_re   = 1'b1;
                  state_in = ST_SHR_WR;
               end else begin
                  counts_in[zidx]   = cur_ff;
                  res_in.ok         = 1'b1;
                  res_in.page_count = 11'(cur_ff);
                  state_in          = ST_DONE;
               end
            end
            ST_SHR_WR: begin
               // A released page below the reserve is freed but not counted.
               if (int'(mem_rdata) < PHYS_PAGES) begin
                  used_we    = 1'b1;
                  used_waddr = mem_rdata;
                  if (int'(mem_rdata) >= int'(held_ff)) begin
                     free_in = free_ff + 1'b1;
                  end
               end
               cur_in   = cur_ff - 1'b1;
               state_in = ST_SHR_RD;
            end
            ST_XLAT: begin
               res_in.ok            = 1'b1;
               res_in.physical_page = 7'(mem_rdata);
               state_in             = ST_DONE;
            end
            ST_DONE: begin
               if (slot_free) begin
                  res_valid = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (used_re) begin
         used_rdata <= used_mem[used_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= FREE_W'(PHYS_PAGES);
         held_ff <= '0;
         scan_ff <= '0;
         chk_ff  <= 1'b0;
         for (int z = 0; z < NUM_ZONES; z++) begin
            counts_ff[z] <= '0;
         end
      end else begin
         free_ff   <= free_in;
         held_ff   <= held_in;
         scan_ff   <= scan_in;
         chk_ff    <= chk_in;
         counts_ff <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      cur_ff  <= cur_in;
      need_ff <= need_in;
   end

   // Only pages above the reserve are counted, each at most once.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      int'(free_ff) + int'(held_ff) <= PHYS_PAGES)
      else $error("free count exceeds unreserved pages");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ready && !csr_we) |=> (state_ff == ST_EVAL))
      else $error("accepted request not evaluated");

   a_shrink_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHR_WR) |-> ($past(state_ff) == ST_SHR_RD && $past(mem_re)))
      else $error("shrink release without a map read");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (slot_free && state_ff == ST_DONE))
      else $error("result issued without a free output slot");

endmodule

// File: rtl/zone_page_allocator.sv
// Zone page allocator, top level.
// Holds the response register and the stream ports; depends on zpa_pkg,
// zpa_ctrl and zpa_map_ram.
//
// Requests enter on the req_ stream: tuser is the mode (resize or
// translate), tdata the zone, size in words and virtual page. Every request
// yields one response on the rsp_ stream. The user must write the reserved page
// count via csr_we and csr_wdata only with no request in flight (not enforced).
//
// One request is worked on at a time. A translate passes through evaluation,
// the registered read of the zone map memory and the result register. A grow
// scans the page ownership bits one page per cycle from the reserve upward
// until the zone has enough pages or the scan ends; a shrink reads the zone
// map once per released page and clears that page's ownership bit. Refused
// requests go from evaluation straight to the result. A register write starts
// a recount of the free pages, during which no request is accepted.
//
// Reset is synchronous: all zones are empty and the reserve is zero. A
// clearing pass then marks every page free; no request is accepted until it
// ends. The zone map holds no reset value; only entries below a zone's page
// count are ever read. A finished response waits in the output register while
// rsp_tready is low; the next request is still accepted and is held in its
// last state until the register frees up.
module zone_page_allocator
   import zpa_pkg::*;
#(
   parameter int PHYS_PAGES       = PHYS_PAGES_DEF,
   parameter int SMALL_ZONE_PAGES = SMALL_ZONE_PAGES_DEF,
   parameter int LARGE_ZONE_PAGES = LARGE_ZONE_PAGES_DEF,
   parameter int NUM_ZONES        = NUM_ZONES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // zone[2:0], size_words[24:3], virtual_page[34:25]
   input  logic        req_tuser,  // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // ok[0], page_count[11:1], free_pages[19:12],
                                   // physical_page[26:20]
);

   localparam int MAP_ROW = (SMALL_ZONE_PAGES > LARGE_ZONE_PAGES) ?
                            SMALL_ZONE_PAGES : LARGE_ZONE_PAGES;
   localparam int DEPTH   = NUM_ZONES * MAP_ROW;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PAGE_W  = $clog2(PHYS_PAGES);

   request_type       req;
   result_type        res;
   logic              req_ready;
   logic              res_valid;
   logic              slot_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [PAGE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [PAGE_W-1:0] mem_rdata;

   assign req.mode         = req_tuser;
   assign req.zone         = req_tdata[2:0];
   assign req.size_words   = req_tdata[24:3];
   assign req.virtual_page = req_tdata[34:25];

   assign req_tready = req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   zpa_ctrl #(
      .PHYS_PAGES       (PHYS_PAGES),
      .SMALL_ZONE_PAGES (SMALL_ZONE_PAGES),
      .LARGE_ZONE_PAGES (LARGE_ZONE_PAGES),
      .NUM_ZONES        (NUM_ZONES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_accept (req_tvalid),
      .req        (req),
      .req_ready  (req_ready),
      .slot_free  (slot_free),
      .res_valid  (res_valid),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   zpa_map_ram #(
      .DEPTH  (DEPTH),
      .DATA_W (PAGE_W)
   ) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, res.physical_page, res.free_pages, res.page_count, res.ok};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: test/zone_page_allocator_test.sv
// Self-checking bench for zone_page_allocator: directed and random resize and
// translate requests, each checked against an in-bench model of the page tables.
// Depends on zpa_pkg and the zone_page_allocator RTL.
module zone_page_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import zpa_pkg::*;

   localparam int PAGES          = PHYS_PAGES_DEF;
   localparam int WORDS_PER_PAGE = 1 << PAGE_SHIFT;
   localparam int MAP_DEPTH      = (SMALL_ZONE_PAGES_DEF > LARGE_ZONE_PAGES_DEF) ?
                                   SMALL_ZONE_PAGES_DEF : LARGE_ZONE_PAGES_DEF;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_PRINTED    = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   // Allocator state as the bench believes it to be.
   logic [7:0]  reserve_reg;
   logic [6:0]  zone_pages [NUM_ZONES_DEF][MAP_DEPTH];
   logic [13:0] page_owner_tag [PAGES];
   int unsigned held [NUM_ZONES_DEF];
   int unsigned free_total;

   result_type  answers_due [$];
   int unsigned answer_index = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned send_idle_pct  = 20;
   int unsigned rsp_stall_pct  = 20;

   zone_page_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned reserve_floor();
      return (reserve_reg > PAGES) ? PAGES : reserve_reg;
   endfunction

   function automatic void recount_free_pages();
      free_total = 0;
      for (int p = reserve_floor(); p < PAGES; p++)
         if (page_owner_tag[p] == '0) free_total++;
   endfunction

   // Applies one request to the page tables and returns the response it yields.
   function automatic result_type allocate_pages(input request_type r);
      result_type  res;
      int unsigned need, cur, limit, p, floor_page;
      res = '0;
      if (r.zone < NUM_ZONES_DEF) begin
         limit = (r.zone == LARGE_ZONE_ID) ? LARGE_ZONE_PAGES_DEF : SMALL_ZONE_PAGES_DEF;
         cur = held[r.zone];
         if (r.mode == MODE_TRANSLATE) begin
            if (r.virtual_page < cur && r.virtual_page < MAP_DEPTH) begin
               res.ok = 1'b1;
               res.physical_page = zone_pages[r.zone][r.virtual_page];
            end
         end else begin
            need = (32'(r.size_words) + 32'(WORD_ROUND)) >> PAGE_SHIFT;
            if (need <= limit && need <= MAP_DEPTH) begin
               if (need > cur) begin
                  // Growth takes the lowest free pages above the reserve.
                  if (need - cur <= free_total) begin
                     for (p = reserve_floor(); p < PAGES && cur < need; p++) begin
                        if (page_owner_tag[p] == '0) begin
                           page_owner_tag[p] = {1'b1, r.zone, cur[9:0]};
                           zone_pages[r.zone][cur] = p[6:0];
                           cur++;
                           free_total--;
                        end
                     end
                     res.ok = (cur == need);
                  end
               end else begin
                  // A page under the reserve goes free but is not counted.
                  floor_page = reserve_floor();
                  while (cur > need) begin
                     p = zone_pages[r.zone][cur - 1];
                     page_owner_tag[p] = '0;
                     if (p >= floor_page) free_total++;
                     cur--;
                  end
                  res.ok = 1'b1;
               end
               held[r.zone] = cur;
            end
         end
         res.page_count = held[r.zone][10:0];
      end
      res.free_pages = free_total[7:0];
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap(input int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) $display("error: %s", msg);
      error_count++;
   endtask

   task automatic send_request(input request_type r);
      int gap;
      gap = idle_gap(send_idle_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, r.virtual_page, r.size_words, r.zone};
      req_tuser  <= r.mode;
      do @(posedge clock); while (req_tready !== 1'b1);
      answers_due.push_back(allocate_pages(r));
   endtask

   task automatic resize_zone(input logic [2:0] zone, input int unsigned words);
      request_type r;
      r = '0;
      r.mode = MODE_RESIZE;
      r.zone = zone;
      r.size_words = words[21:0];
      send_request(r);
   endtask

   task automatic translate_page(input logic [2:0] zone, input logic [9:0] vpage);
      request_type r;
      r = '0;
      r.mode = MODE_TRANSLATE;
      r.zone = zone;
      r.virtual_page = vpage;
      send_request(r);
   endtask

   // Leaves the request side quiet until every response is back.
   task automatic drain_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reserve(input logic [7:0] value);
      drain_answers();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      reserve_reg = value;
      recount_free_pages();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_empty_and_invalid_zones();
      translate_page(3'd0, 10'd0);
      resize_zone(3'd6, 5000);
      translate_page(3'd7, 10'd1023);
   endtask

   task automatic test_size_limits();
      resize_zone(3'd0, 1);
      resize_zone(3'd0, SMALL_ZONE_PAGES_DEF * WORDS_PER_PAGE);
      resize_zone(3'd0, SMALL_ZONE_PAGES_DEF * WORDS_PER_PAGE + 1);
      resize_zone(LARGE_ZONE_ID, 22'h3FFFFF);
      resize_zone(LARGE_ZONE_ID, LARGE_ZONE_PAGES_DEF * WORDS_PER_PAGE);
      resize_zone(3'd5, WORDS_PER_PAGE + 1);
      resize_zone(3'd5, 2 * WORDS_PER_PAGE);
      resize_zone(3'd0, 0);
   endtask

   task automatic test_free_page_exhaustion();
      resize_zone(LARGE_ZONE_ID, free_total * WORDS_PER_PAGE);
      resize_zone(3'd1, 1);
      translate_page(LARGE_ZONE_ID, 10'(held[LARGE_ZONE_ID] - 1));
      translate_page(LARGE_ZONE_ID, 10'(held[LARGE_ZONE_ID]));
      resize_zone(LARGE_ZONE_ID, 100 * WORDS_PER_PAGE - 5);
      translate_page(3'd5, 10'd1);
   endtask

   task automatic test_reserve_changes();
      write_reserve(8'd128);
      resize_zone(LARGE_ZONE_ID, 50 * WORDS_PER_PAGE);
      resize_zone(3'd2, 1);
      write_reserve(8'd255);
      resize_zone(3'd5, 0);
      write_reserve(8'd10);
      resize_zone(3'd3, 3000);
      write_reserve(8'd0);
      resize_zone(3'd1, WORDS_PER_PAGE);
      translate_page(3'd1, 10'd0);
   endtask

   // Phases of mostly well-formed traffic under changing reserves, with some
   // requests of entirely random fields mixed in.
   task automatic test_random_traffic();
      request_type r;
      int unsigned pages, limit, cur, pick, count;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0, 7:    write_reserve(8'd0);
            2:       write_reserve(8'($urandom_range(0, 16)));
            3:       write_reserve(8'd128);
            5:       write_reserve(8'($urandom_range(129, 255)));
            6:       write_reserve(8'd127);
            default: write_reserve(8'($urandom_range(1, 127)));
         endcase
         send_idle_pct = (phase == 2 || phase == 4) ? 0 : 25;
         rsp_stall_pct = (phase == 2) ? 0 : 25;
         count = (phase == 3 || phase == 5) ? 40 : 150;
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            r = '0;
            if (pick < 8) begin
               r.mode = 1'($urandom_range(0, 1));
               r.zone = 3'($urandom_range(0, 7));
               r.size_words = 22'($urandom);
               r.virtual_page = 10'($urandom);
            end else begin
               r.zone = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
                                                        3'($urandom_range(0, 5));
               limit = (r.zone == LARGE_ZONE_ID) ? LARGE_ZONE_PAGES_DEF : SMALL_ZONE_PAGES_DEF;
               cur = (r.zone < NUM_ZONES_DEF) ? held[r.zone] : 0;
               if (pick < 45) begin
                  r.mode = MODE_TRANSLATE;
                  r.size_words = 22'($urandom);
                  r.virtual_page = ($urandom_range(0, 4) == 0) ? 10'($urandom) :
                                                                 10'($urandom_range(0, cur + 1));
               end else begin
                  r.mode = MODE_RESIZE;
                  pick = $urandom_range(0, 99);
                  if (pick < 65) pages = $urandom_range(0, 24);
                  else if (pick < 77) pages = cur;
                  else if (pick < 89) pages = $urandom_range(25, PAGES);
                  else pages = $urandom_range(limit - 4, limit + 4);
                  r.size_words = (pages == 0) ? 22'd0 :
                     22'(pages * WORDS_PER_PAGE - $urandom_range(0, WORDS_PER_PAGE - 1));
                  r.virtual_page = 10'($urandom);
               end
            end
            send_request(r);
         end
      end
   endtask

   // Response side: ready drops for random stretches once reset is over.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = idle_gap(rsp_stall_pct);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_answers
      result_type want, got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.ok            = rsp_tdata[0];
         got.page_count    = rsp_tdata[11:1];
         got.free_pages    = rsp_tdata[19:12];
         got.physical_page = rsp_tdata[26:20];
         if (answers_due.size() == 0) begin
            report_error($sformatf("response %0d arrived with no request pending",
                                   answer_index));
         end else begin
            want = answers_due.pop_front();
            if (got.ok !== want.ok)
               report_error($sformatf("response %0d ok: got %0d, expected %0d",
                                      answer_index, got.ok, want.ok));
            if (got.page_count !== want.page_count)
               report_error($sformatf("response %0d page_count: got %0d, expected %0d",
                                      answer_index, got.page_count, want.page_count));
            if (got.free_pages !== want.free_pages)
               report_error($sformatf("response %0d free_pages: got %0d, expected %0d",
                                      answer_index, got.free_pages, want.free_pages));
            if (got.physical_page !== want.physical_page)
               report_error($sformatf("response %0d physical_page: got %0d, expected %0d",
                                      answer_index, got.physical_page, want.physical_page));
         end
         answer_index++;
      end
   end

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = 8'd0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      reserve_reg = 8'd0;
      foreach (page_owner_tag[p]) page_owner_tag[p] = '0;
      foreach (held[z]) held[z] = 0;
      recount_free_pages();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_invalid_zones();
      test_size_limits();
      test_free_page_exhaustion();
      test_reserve_changes();
      test_random_traffic();

      drain_answers();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
rtl/zpa_pkg.sv
rtl/zpa_map_ram.sv
rtl/zpa_ctrl.sv
rtl/zone_page_allocator.sv
test/zone_page_allocator_test.sv
